// File: sv/scs_pkg.sv
package scs_pkg;

    // Default number of frames held on the shadow stack
    localparam int SCS_DEPTH = 64;

    // Field widths
    localparam int ADDR_W = 32;

    // Input beat: tdata holds block_address, call_site, call_target,
    // return_address and stack_pointer; tuser holds func
    localparam int S_TDATA_W = 5 * ADDR_W;
    localparam int S_TUSER_W = 1;

    // Result beat: tdata holds from, to, frame return address and frame
    // stack pointer; tuser holds event_kind and overflow
    localparam int M_TDATA_W = 4 * ADDR_W;
    localparam int KIND_W    = 2;
    localparam int M_TUSER_W = KIND_W + 1;

    // Input event codes
    localparam logic FUNC_CALL  = 1'b0;
    localparam logic FUNC_BLOCK = 1'b1;

    // Result event codes
    localparam logic [KIND_W-1:0] KIND_CALL   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RET    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MISSED = 2'd2;

    // One stored frame: saved stack pointer above return address
    typedef struct packed {
        logic [ADDR_W-1:0] sp;
        logic [ADDR_W-1:0] ra;
    } frame_t;

    localparam int FRAME_W = $bits(frame_t);

endpackage

// File: sv/scs_ram.sv
module scs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/shadow_call_stack_tracker.sv
// A call beat's result is registered in the cycle after acceptance. A block beat
// reads the top frame, then, once the output is free, pops it as a return,
// unwinds through the frames below when two or more are held, or gives no
// result, as an empty stack does. Beats are taken only in ST_IDLE with the output
// free; an unwind reads one frame per cycle unless the output stalls. Reset:
// synchronous, active low; the stack is emptied at once, RAM contents not cleared.
module shadow_call_stack_tracker #(
    parameter int DEPTH = scs_pkg::SCS_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input beats
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // block_address, call_site, call_target, return_address, stack_pointer
    input  logic [scs_pkg::S_TDATA_W-1:0]  s_tdata,
    // func
    input  logic [scs_pkg::S_TUSER_W-1:0]  s_tuser,
    // result beats
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // from_address, to_address, frame_return_address, frame_stack_pointer
    output logic [scs_pkg::M_TDATA_W-1:0]  m_tdata,
    // event_kind[1:0], overflow
    output logic [scs_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tlast
);

    import scs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_TWO  = CW'(2);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RD_TOP = 4'b0010,
        ST_UNWIND = 4'b0100,
        ST_FINAL  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    frame_t            held_reg, held_next;
    logic [ADDR_W-1:0] blk_reg, blk_next;
    logic [ADDR_W-1:0] sp_reg, sp_next;

    logic              m_valid_reg, m_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [ADDR_W-1:0] from_reg, from_next;
    logic [ADDR_W-1:0] to_reg, to_next;
    logic [ADDR_W-1:0] fra_reg, fra_next;
    logic [ADDR_W-1:0] fsp_reg, fsp_next;
    logic              ovf_reg, ovf_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic              s_accept;
    logic              in_func;
    logic [ADDR_W-1:0] in_blk, in_site, in_target, in_ret, in_sp;

    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    frame_t            wr_frame, rd_frame;
    logic [FRAME_W-1:0] rd_data;
    logic [CW-1:0]     cnt_m1, cnt_m2, cnt_m3;
    logic              next_qual;

    // Unpack the input beat
    assign in_func   = s_tuser[0];
    assign in_blk    = s_tdata[0*ADDR_W +: ADDR_W];
    assign in_site   = s_tdata[1*ADDR_W +: ADDR_W];
    assign in_target = s_tdata[2*ADDR_W +: ADDR_W];
    assign in_ret    = s_tdata[3*ADDR_W +: ADDR_W];
    assign in_sp     = s_tdata[4*ADDR_W +: ADDR_W];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    assign cnt_m1 = count_reg - CNT_ONE;
    assign cnt_m2 = count_reg - CNT_TWO;
    assign cnt_m3 = cnt_m2 - CNT_ONE;

    assign rd_frame  = frame_t'(rd_data);
    assign next_qual = sp_reg > rd_frame.sp;

    // Frame memory; the sequencer never reads while a write is in flight,
    // so no forwarding is needed
    scs_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_frame),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer: push on calls (or flag overflow when full), match or unwind on block beats
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        held_next    = held_reg;
        blk_next     = blk_reg;
        sp_next      = sp_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[AW-1:0];
        wr_frame     = '{sp: in_sp, ra: in_ret};
        rd_en        = 1'b0;
        rd_addr      = cnt_m1[AW-1:0];
        m_valid_next = m_valid_reg && !m_tready;
        kind_next    = kind_reg;
        from_next    = from_reg;
        to_next      = to_reg;
        fra_next     = fra_reg;
        fsp_next     = fsp_reg;
        ovf_next     = ovf_reg;
        last_next    = last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (in_func == FUNC_CALL) begin
                        m_valid_next = 1'b1;
                        kind_next    = KIND_CALL;
                        from_next    = in_site;
                        to_next      = in_target;
                        fra_next     = in_ret;
                        fsp_next     = in_sp;
                        last_next    = 1'b1;
                        ovf_next     = (count_reg == CNT_FULL);
                        if (count_reg != CNT_FULL) begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_ONE;
                        end
                    end else begin
                        blk_next = in_blk;
                        sp_next  = in_sp;
                        if (count_reg != '0) begin
                            rd_en      = 1'b1;
                            rd_addr    = cnt_m1[AW-1:0];
                            state_next = ST_RD_TOP;
                        end
                    end
                end
            end
            ST_RD_TOP: begin
                if (out_free) begin
                    if (blk_reg == rd_frame.ra ||
                        (next_qual && count_reg == CNT_ONE)) begin
                        // pop exactly one frame as a return
                        m_valid_next = 1'b1;
                        kind_next    = KIND_RET;
                        from_next    = '0;
                        to_next      = rd_frame.ra;
                        fra_next     = '0;
                        fsp_next     = rd_frame.sp;
                        ovf_next     = 1'b0;
                        last_next    = 1'b1;
                        count_next   = cnt_m1;
                        state_next   = ST_IDLE;
                    end else if (next_qual) begin
                        // hold the top frame, look at the one below
                        held_next  = rd_frame;
                        rd_en      = 1'b1;
                        rd_addr    = cnt_m2[AW-1:0];
                        state_next = ST_UNWIND;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_UNWIND: begin
                if (out_free) begin
                    // emit the held frame; its kind depends on the frame below
                    m_valid_next = 1'b1;
                    kind_next    = next_qual ? KIND_MISSED : KIND_RET;
                    from_next    = '0;
                    to_next      = held_reg.ra;
                    fra_next     = '0;
                    fsp_next     = held_reg.sp;
                    ovf_next     = 1'b0;
                    last_next    = !next_qual;
                    count_next   = cnt_m1;
                    if (!next_qual) begin
                        state_next = ST_IDLE;
                    end else begin
                        held_next = rd_frame;
                        if (count_reg == CNT_TWO) begin
                            state_next = ST_FINAL;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = cnt_m3[AW-1:0];
                        end
                    end
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    // bottom frame popped: it closes the run as a return
                    m_valid_next = 1'b1;
                    kind_next    = KIND_RET;
                    from_next    = '0;
                    to_next      = held_reg.ra;
                    fra_next     = '0;
                    fsp_next     = held_reg.sp;
                    ovf_next     = 1'b0;
                    last_next    = 1'b1;
                    count_next   = cnt_m1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        blk_reg  <= blk_next;
        sp_reg   <= sp_next;
        kind_reg <= kind_next;
        from_reg <= from_next;
        to_reg   <= to_next;
        fra_reg  <= fra_next;
        fsp_reg  <= fsp_next;
        ovf_reg  <= ovf_next;
        last_reg <= last_next;
    end

    // Drive the result beat
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {fsp_reg, fra_reg, to_reg, from_reg};
    assign m_tuser  = {ovf_reg, kind_reg};
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_unwind_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UNWIND |-> count_reg >= CNT_TWO)
        else $error("unwinding with fewer than two frames");

    a_final_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINAL |-> count_reg == CNT_ONE)
        else $error("final pop without exactly one frame");

    a_ovf_call: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && ovf_reg |-> kind_reg == KIND_CALL && count_reg == CNT_FULL)
        else $error("overflow on a non-call or with room left");

    a_push: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && in_func == FUNC_CALL && count_reg != CNT_FULL
        |=> count_reg == $past(count_reg) + CNT_ONE)
        else $error("call did not push a frame");
`endif

endmodule
